>>> sv/fwhm_pkg.sv
// Shared types and constants for the histogram FWHM peak block.
package fwhm_pkg;

  localparam int AXIS_W  = 32;             // axis_start register
  localparam int STEP_W  = 24;             // bin_step register
  localparam int CFG_W   = 32;             // widest configuration register
  localparam int IN_W    = 32;             // bin_value field
  localparam int WIDTH_W = 47;             // width result field
  localparam int POS_W   = 48;             // peak_pos result field
  localparam int QB      = STEP_W + 1;     // quotient bits of the interpolation divide
  localparam int OUT_DW  = 96;             // width + peak_pos, padded to bytes
  localparam int OUT_UW  = 2;              // valid_res, overflow

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_AXIS_START = 1'b0;
  localparam cfg_idx_t CFG_BIN_STEP   = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PK_MUL,
    ST_PK_SET,
    ST_L_RD,
    ST_L_CHK,
    ST_L_MUL,
    ST_L_DIV,
    ST_L_WAIT,
    ST_R_FB,
    ST_R_INIT,
    ST_R_RD,
    ST_R_CHK,
    ST_R_MUL,
    ST_R_DIV,
    ST_R_WAIT,
    ST_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_PK_MUL,   // product of peak centre offset
    OP_PK_SET,   // latch peak centre, arm left walk
    OP_L_STEP,   // read next bin to the left
    OP_L_CHK,    // test left bin against half height
    OP_L_MUL,    // left centre offset and divide numerator
    OP_L_BASE,   // left base position, start divide
    OP_L_ADDQ,   // add quotient to left crossing
    OP_R_FB,     // product for right axis edge
    OP_R_INIT,   // right fallback, arm right walk
    OP_R_STEP,   // read next bin to the right
    OP_R_CHK,    // test right bin against half height
    OP_R_MUL,    // right centre offset and divide numerator
    OP_R_BASE,   // right base position, start divide
    OP_R_ADDQ,   // add quotient to right crossing
    OP_FIN       // load result register, clear histogram state
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   in_ready;
  } ctrl_cmd_t;

  typedef struct packed {
    logic below;      // bin just read is below half the peak
    logic idx_zero;   // left walk reached bin 0
    logic idx_end;    // right walk reached the last stored bin
    logic peak_zero;
    logic div_done;
    logic out_free;   // result register can take a new result
  } dp_stat_t;

endpackage

>>> sv/histogram_fwhm_peak.sv
// Top level of the histogram full-width-at-half-maximum peak finder.
//
// Histogram bins stream in one per cycle while the block is idle and are written to an on-chip
// bin memory while the first highest bin is tracked; bins beyond MAX_BINS are dropped and raise
// the overflow flag. After the bin marked tlast the input stalls while the block walks left and
// then right from the peak, each bin visited taking one registered read of the bin memory and one
// test against half height. Each side that finds a crossing then does one multiply, loads the
// 25-step radix-2 divider and waits on it; a side without a crossing uses that axis edge. The
// result waits in an output register, so loading of the next histogram starts as soon as the
// result is registered. Positions use axis_start and bin_step with eight fractional bits; a zero
// peak gives valid_res = 0 with zero width and position.
module histogram_fwhm_peak #(
  parameter int MAX_BINS   = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  fwhm_pkg::cfg_idx_t            cfg_addr,
  input  logic [fwhm_pkg::CFG_W-1:0]    cfg_wdata,
  // bin stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fwhm_pkg::IN_W-1:0]     in_tdata,   // [31:0] bin_value
  input  logic                          in_tlast,
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [fwhm_pkg::OUT_DW-1:0]   out_tdata,  // [46:0] width, [94:47] peak_pos, pad
  output logic [fwhm_pkg::OUT_UW-1:0]   out_tuser   // [0] valid_res, [1] overflow
);
  import fwhm_pkg::*;

  ctrl_cmd_t            cmd;
  dp_stat_t             stat;
  logic                 in_acc;
  logic [WIDTH_W-1:0]   width;
  logic [POS_W-1:0]     peak_pos;
  logic                 valid_res, overflow;

  assign in_tready = cmd.in_ready;
  assign in_acc    = in_tvalid && cmd.in_ready;

  fwhm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .last_acc (in_acc && in_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  fwhm_dp #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .load      (in_acc),
    .bin_value (in_tdata),
    .op        (cmd.op),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .width     (width),
    .peak_pos  (peak_pos),
    .valid_res (valid_res),
    .overflow  (overflow)
  );

  assign out_tdata = {(OUT_DW - WIDTH_W - POS_W)'(0), peak_pos, width};
  assign out_tuser = {overflow, valid_res};

  // The scan holds off new bins right after the closing bin.
  a_stall_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("bin accepted right after the closing bin");

  // A new result is only produced while input is held off.
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared outside the scan");

  // An invalid result carries zero width and position.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("invalid result with nonzero payload");

endmodule

>>> sv/fwhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fwhm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/fwhm_div.sv
// Radix-2 restoring divider: floor(prod / den), quotient known to fit QB bits.
module fwhm_div #(
  parameter int DEN_W = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [DEN_W+fwhm_pkg::QB-1:0]    prod,
  input  logic [DEN_W-1:0]                 den,
  output logic [fwhm_pkg::QB-1:0]          q,
  output logic                             done
);
  import fwhm_pkg::*;

  localparam int CNT_W = $clog2(QB + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [QB-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  // Shift the next dividend bit in; quotient bits fill lo_r from the bottom.
  always_comb begin
    trial   = {rem_r, lo_r[QB-1]};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
    lo_nxt  = {lo_r[QB-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(QB);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= prod[DEN_W+QB-1:QB];
      lo_r  <= prod[QB-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign q    = lo_r;
  assign done = done_r;

endmodule

>>> sv/fwhm_dp.sv
// Datapath: bin store, peak tracking, centre arithmetic, crossings and result register.
module fwhm_dp #(
  parameter int MAX_BINS   = 1024,
  parameter int COUNT_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  fwhm_pkg::cfg_idx_t             cfg_addr,
  input  logic [fwhm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           load,
  input  logic [fwhm_pkg::IN_W-1:0]      bin_value,
  input  fwhm_pkg::dp_op_t               op,
  output fwhm_pkg::dp_stat_t             stat,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [fwhm_pkg::WIDTH_W-1:0]   width,
  output logic [fwhm_pkg::POS_W-1:0]     peak_pos,
  output logic                           valid_res,
  output logic                           overflow
);
  import fwhm_pkg::*;

  localparam int IW  = $clog2(MAX_BINS);
  localparam int NW  = IW + 1;
  localparam int CW  = (COUNT_BITS < IN_W) ? COUNT_BITS : IN_W;
  localparam int MW  = IW + 1 + STEP_W;
  localparam int PRW = CW + 1 + STEP_W;
  localparam int PW  = ((IW + 26 > 34) ? IW + 26 : 34) + 2;

  // configuration
  logic signed [AXIS_W-1:0] axis_r;
  logic [STEP_W-1:0]        step_r;

  // histogram state
  logic [NW-1:0] cnt_r;
  logic [CW-1:0] peak_r;
  logic [IW-1:0] pidx_r;
  logic          ovf_r;

  // walk and arithmetic
  logic [IW-1:0]          idx_r;
  logic [CW-1:0]          prev_r;
  logic [CW:0]            num_r;
  logic [CW-1:0]          den_r;
  logic [MW-1:0]          mul_r;
  logic [PRW-1:0]         prod_r;
  logic signed [PW-1:0]   pk_r, left_r, right_r;

  // result register
  logic                   out_valid_r;
  logic [WIDTH_W-1:0]     width_r;
  logic [POS_W-1:0]       pos_r;
  logic                   vres_r, ovf_out_r;

  logic [CW-1:0]          y_in, rdata;
  logic                   store_ok;
  logic [IW-1:0]          raddr;
  logic [IW:0]            mul_a;
  logic [MW-1:0]          mul_p;
  logic signed [PW-1:0]   axis2, centre, fb, q_ext;
  logic [QB-1:0]          q;
  logic                   div_start, div_done;
  logic signed [PW:0]     w, wh;
  logic signed [PW-1:0]   ph;

  assign y_in     = bin_value[CW-1:0];
  assign store_ok = cnt_r < NW'(MAX_BINS);

  always_comb begin
    case (op)
      OP_L_STEP: raddr = idx_r - 1'b1;
      OP_R_STEP: raddr = idx_r + 1'b1;
      default:   raddr = idx_r;
    endcase
  end

  fwhm_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (load && store_ok),
    .waddr (cnt_r[IW-1:0]),
    .wdata (y_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign div_start = (op == OP_L_BASE) || (op == OP_R_BASE);

  fwhm_div #(
    .DEN_W (CW)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .prod  (prod_r),
    .den   (den_r),
    .q     (q),
    .done  (div_done)
  );

  // Odd multiplier gives bin centres in half-bin units; count gives the right edge.
  always_comb begin
    case (op)
      OP_PK_MUL: mul_a = {pidx_r, 1'b1};
      OP_L_MUL:  mul_a = {idx_r, 1'b1};
      OP_R_MUL:  mul_a = {IW'(idx_r - 1'b1), 1'b1};
      OP_R_FB:   mul_a = cnt_r;
      default:   mul_a = '0;
    endcase
  end

  assign mul_p  = mul_a * step_r;
  assign axis2  = PW'(axis_r) <<< 1;
  assign centre = axis2 + $signed(PW'(mul_r));
  assign fb     = axis2 + $signed(PW'({mul_r, 1'b0}));
  assign q_ext  = $signed(PW'(q));

  // Round half up: add one half-unit, then floor-halve.
  assign w  = {right_r[PW-1], right_r} - {left_r[PW-1], left_r};
  assign wh = (w + $signed((PW+1)'(1))) >>> 1;
  assign ph = (pk_r + $signed(PW'(1))) >>> 1;

  always_comb begin
    stat.below     = {rdata, 1'b0} < {1'b0, peak_r};
    stat.idx_zero  = idx_r == '0;
    stat.idx_end   = ({1'b0, idx_r} + 1'b1) == cnt_r;
    stat.peak_zero = peak_r == '0;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid_r || out_ready;
  end

  // control-side registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_r      <= '0;
      step_r      <= STEP_W'(256);
      cnt_r       <= '0;
      peak_r      <= '0;
      pidx_r      <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_AXIS_START: axis_r <= $signed(cfg_wdata[AXIS_W-1:0]);
          CFG_BIN_STEP:   step_r <= cfg_wdata[STEP_W-1:0];
        endcase
      end
      if (load) begin
        if (store_ok) begin
          cnt_r <= cnt_r + 1'b1;
          if (y_in > peak_r) begin
            peak_r <= y_in;
            pidx_r <= cnt_r[IW-1:0];
          end
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (op == OP_FIN) begin
        cnt_r       <= '0;
        peak_r      <= '0;
        pidx_r      <= '0;
        ovf_r       <= 1'b0;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (op)
      OP_PK_MUL, OP_R_FB: mul_r <= mul_p;
      OP_PK_SET: begin
        pk_r   <= centre;
        left_r <= axis2;
        idx_r  <= pidx_r;
        prev_r <= peak_r;
      end
      OP_L_STEP: idx_r <= idx_r - 1'b1;
      OP_R_STEP: idx_r <= idx_r + 1'b1;
      OP_L_CHK: begin
        if (stat.below) begin
          num_r <= {1'b0, peak_r} - {rdata, 1'b0};
          den_r <= prev_r - rdata;
        end else begin
          prev_r <= rdata;
        end
      end
      OP_R_CHK: begin
        if (stat.below) begin
          num_r <= {prev_r, 1'b0} - {1'b0, peak_r};
          den_r <= prev_r - rdata;
        end else begin
          prev_r <= rdata;
        end
      end
      OP_L_MUL, OP_R_MUL: begin
        mul_r  <= mul_p;
        prod_r <= num_r * step_r;
      end
      OP_L_BASE: left_r  <= centre;
      OP_R_BASE: right_r <= centre;
      OP_L_ADDQ: left_r  <= left_r + q_ext;
      OP_R_ADDQ: right_r <= right_r + q_ext;
      OP_R_INIT: begin
        right_r <= fb;
        idx_r   <= pidx_r;
        prev_r  <= peak_r;
      end
      OP_FIN: begin
        vres_r    <= peak_r != '0;
        ovf_out_r <= ovf_r;
        if (peak_r == '0) begin
          width_r <= '0;
          pos_r   <= '0;
        end else begin
          width_r <= w[PW] ? '0 : WIDTH_W'($unsigned(wh));
          pos_r   <= POS_W'(ph);
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign width     = width_r;
  assign peak_pos  = pos_r;
  assign valid_res = vres_r;
  assign overflow  = ovf_out_r;

endmodule

>>> sv/fwhm_ctrl.sv
// Controller: sequences loading, the two half-height walks and result hand-off.
module fwhm_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 last_acc,
  input  fwhm_pkg::dp_stat_t   stat,
  output fwhm_pkg::ctrl_cmd_t  cmd
);
  import fwhm_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (last_acc) state_nxt = ST_PK_MUL;
      ST_PK_MUL: state_nxt = ST_PK_SET;
      ST_PK_SET: state_nxt = stat.peak_zero ? ST_FIN : ST_L_RD;
      ST_L_RD:   state_nxt = stat.idx_zero ? ST_R_FB : ST_L_CHK;
      ST_L_CHK:  state_nxt = stat.below ? ST_L_MUL : ST_L_RD;
      ST_L_MUL:  state_nxt = ST_L_DIV;
      ST_L_DIV:  state_nxt = ST_L_WAIT;
      ST_L_WAIT: if (stat.div_done) state_nxt = ST_R_FB;
      ST_R_FB:   state_nxt = ST_R_INIT;
      ST_R_INIT: state_nxt = ST_R_RD;
      ST_R_RD:   state_nxt = stat.idx_end ? ST_FIN : ST_R_CHK;
      ST_R_CHK:  state_nxt = stat.below ? ST_R_MUL : ST_R_RD;
      ST_R_MUL:  state_nxt = ST_R_DIV;
      ST_R_DIV:  state_nxt = ST_R_WAIT;
      ST_R_WAIT: if (stat.div_done) state_nxt = ST_FIN;
      ST_FIN:    if (stat.out_free) state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.in_ready = 1'b0;
    cmd.op       = OP_NONE;
    unique case (state_r)
      ST_IDLE:   cmd.in_ready = 1'b1;
      ST_PK_MUL: cmd.op = OP_PK_MUL;
      ST_PK_SET: cmd.op = OP_PK_SET;
      ST_L_RD:   cmd.op = stat.idx_zero ? OP_NONE : OP_L_STEP;
      ST_L_CHK:  cmd.op = OP_L_CHK;
      ST_L_MUL:  cmd.op = OP_L_MUL;
      ST_L_DIV:  cmd.op = OP_L_BASE;
      ST_L_WAIT: cmd.op = stat.div_done ? OP_L_ADDQ : OP_NONE;
      ST_R_FB:   cmd.op = OP_R_FB;
      ST_R_INIT: cmd.op = OP_R_INIT;
      ST_R_RD:   cmd.op = stat.idx_end ? OP_NONE : OP_R_STEP;
      ST_R_CHK:  cmd.op = OP_R_CHK;
      ST_R_MUL:  cmd.op = OP_R_MUL;
      ST_R_DIV:  cmd.op = OP_R_BASE;
      ST_R_WAIT: cmd.op = stat.div_done ? OP_R_ADDQ : OP_NONE;
      ST_FIN:    cmd.op = stat.out_free ? OP_FIN : OP_NONE;
    endcase
  end

endmodule
